### rtl/hkrt_pkg.sv
`default_nettype none

package hkrt_pkg;

    // fixed field widths
    localparam int KEY_W   = 7;
    localparam int CFG_W   = 12;
    localparam int DRIFT_W = 13;

    // baseline drift tracking
    localparam int unsigned DRIFT_WINDOW = 15;
    localparam logic [DRIFT_W-1:0] DRIFT_HOLD = 13'd5000;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_REST_BAND           = 3'd0,
        CFG_TRAVEL_FLOOR        = 3'd1,
        CFG_TRIP_DEPTH          = 3'd2,
        CFG_PRESS_SENSITIVITY   = 3'd3,
        CFG_RELEASE_SENSITIVITY = 3'd4
    } cfg_index_t;

    localparam int CFG_IDX_W = 3;

    // register reset values
    localparam logic [CFG_W-1:0] RST_REST_BAND           = 12'd150;
    localparam logic [CFG_W-1:0] RST_TRAVEL_FLOOR        = 12'd1050;
    localparam logic [CFG_W-1:0] RST_TRIP_DEPTH          = 12'd350;
    localparam logic [CFG_W-1:0] RST_PRESS_SENSITIVITY   = 12'd50;
    localparam logic [CFG_W-1:0] RST_RELEASE_SENSITIVITY = 12'd50;

    // register file contents as seen by the datapath
    typedef struct packed {
        logic [CFG_W-1:0] rest_band;
        logic [CFG_W-1:0] travel_floor;
        logic [CFG_W-1:0] trip_depth;
        logic [CFG_W-1:0] press_sensitivity;
        logic [CFG_W-1:0] release_sensitivity;
    } cfg_t;

endpackage

`default_nettype wire

### rtl/hkrt_cfg_regs.sv
`default_nettype none

module hkrt_cfg_regs
    import hkrt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // register select, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_REST_BAND:           cfg_next.rest_band           = cfg_data;
                CFG_TRAVEL_FLOOR:        cfg_next.travel_floor        = cfg_data;
                CFG_TRIP_DEPTH:          cfg_next.trip_depth          = cfg_data;
                CFG_PRESS_SENSITIVITY:   cfg_next.press_sensitivity   = cfg_data;
                CFG_RELEASE_SENSITIVITY: cfg_next.release_sensitivity = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rest_band           <= RST_REST_BAND;
            cfg_reg.travel_floor        <= RST_TRAVEL_FLOOR;
            cfg_reg.trip_depth          <= RST_TRIP_DEPTH;
            cfg_reg.press_sensitivity   <= RST_PRESS_SENSITIVITY;
            cfg_reg.release_sensitivity <= RST_RELEASE_SENSITIVITY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### rtl/hkrt_key_store.sv
`default_nettype none

module hkrt_key_store
#(
    parameter  int DEPTH  = 128,
    parameter  int DATA_W = 8,
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  vld_reg;
    logic [DATA_W-1:0] rd_q_reg;
    logic              ent_vld_reg;
    logic              byp_hit_reg;
    logic [DATA_W-1:0] byp_data_reg;

    // entry storage and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg     <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // per-entry written flags, cleared at reset so untouched keys read zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            ent_vld_reg <= 1'b0;
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                ent_vld_reg <= vld_reg[rd_addr];
                byp_hit_reg <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // write in the same edge as the read wins over the stale array word
    assign rd_data = byp_hit_reg ? byp_data_reg :
                     (ent_vld_reg ? rd_q_reg : '0);

endmodule

`default_nettype wire

### rtl/hkrt_key_update.sv
`default_nettype none

module hkrt_key_update
    import hkrt_pkg::*;
#(
    parameter int ADC_BITS = 12
)
(
    input  cfg_t                     cfg,
    input  wire logic [ADC_BITS-1:0] sample,
    input  wire logic [ADC_BITS-1:0] old_baseline,
    input  wire logic [DRIFT_W-1:0]  old_drift,
    input  wire logic                old_key_down,
    input  wire logic                old_rapid,
    input  wire logic [ADC_BITS-1:0] old_deepest,
    input  wire logic [ADC_BITS-1:0] old_shallowest,
    output logic      [ADC_BITS-1:0] new_baseline,
    output logic      [DRIFT_W-1:0]  new_drift,
    output logic                     new_key_down,
    output logic                     new_rapid,
    output logic      [ADC_BITS-1:0] new_deepest,
    output logic      [ADC_BITS-1:0] new_shallowest,
    output logic                     pressed,
    output logic                     changed
);

    // common compare width for samples and 12-bit registers
    localparam int DW = (ADC_BITS > CFG_W) ? ADC_BITS : CFG_W;
    localparam int LW = DW + 1;

    logic [ADC_BITS-1:0] diff;
    logic [DRIFT_W-1:0]  drift_inc;
    logic [ADC_BITS-1:0] depth;
    logic [ADC_BITS-1:0] depth_c;
    logic [ADC_BITS-1:0] sh_upd;
    logic [ADC_BITS-1:0] deep_upd;
    logic [DW-1:0]       depth_x;
    logic [DW-1:0]       depth_cx;
    logic [DW-1:0]       top_x;
    logic [DW-1:0]       bot_x;
    logic [DW-1:0]       rel_x;
    logic [DW-1:0]       deep_x;
    logic [DW-1:0]       rel_line;
    logic [LW-1:0]       press_sum;
    logic [LW-1:0]       press_line;

    // baseline tracking while released
    always_comb
    begin
        diff         = old_baseline - sample;
        drift_inc    = old_drift + DRIFT_W'(1);
        new_baseline = old_baseline;
        new_drift    = '0;
        if (!old_key_down)
        begin
            if (sample > old_baseline)
            begin
                new_baseline = sample;
            end
            else if ((old_baseline > sample) && (diff < ADC_BITS'(DRIFT_WINDOW)))
            begin
                if (drift_inc > DRIFT_HOLD)
                begin
                    new_baseline = old_baseline - ADC_BITS'(1);
                end
                else
                begin
                    new_drift = drift_inc;
                end
            end
        end
    end

    // depth and its clamp at the bottom deadzone
    always_comb
    begin
        depth    = (new_baseline > sample) ? (new_baseline - sample) : '0;
        depth_x  = DW'(depth);
        top_x    = DW'(cfg.rest_band);
        bot_x    = DW'(cfg.travel_floor);
        rel_x    = DW'(cfg.release_sensitivity);
        depth_c  = (depth_x > bot_x) ? ADC_BITS'(cfg.travel_floor) : depth;
        depth_cx = DW'(depth_c);
    end

    // press and release lines
    always_comb
    begin
        sh_upd     = (depth_c < old_shallowest) ? depth_c : old_shallowest;
        press_sum  = LW'(sh_upd) + LW'(cfg.press_sensitivity);
        press_line = (press_sum > LW'(cfg.travel_floor)) ?
                     LW'(cfg.travel_floor) : press_sum;
        if (!old_rapid)
        begin
            press_line = LW'(cfg.trip_depth);
        end
        deep_upd = (depth_c > old_deepest) ? depth_c : old_deepest;
        deep_x   = DW'(deep_upd);
        rel_line = (deep_x > rel_x) ? (deep_x - rel_x) : '0;
    end

    // key decision
    always_comb
    begin
        new_key_down   = old_key_down;
        new_rapid      = old_rapid;
        new_deepest    = old_deepest;
        new_shallowest = old_shallowest;
        if (depth_x < top_x)
        begin
            new_key_down   = 1'b0;
            new_rapid      = 1'b0;
            new_deepest    = '0;
            new_shallowest = depth;
        end
        else if (!old_key_down)
        begin
            if (old_rapid)
            begin
                new_shallowest = sh_upd;
            end
            if (LW'(depth_cx) >= press_line)
            begin
                new_key_down = 1'b1;
                new_deepest  = depth_c;
            end
        end
        else
        begin
            new_deepest = deep_upd;
            if (depth_cx <= rel_line)
            begin
                new_key_down   = 1'b0;
                new_rapid      = 1'b1;
                new_shallowest = depth_c;
            end
        end
    end

    // the reported state always follows key_down, so a change is an edge of it
    assign pressed = new_key_down;
    assign changed = new_key_down ^ old_key_down;

endmodule

`default_nettype wire

### rtl/hall_key_rapid_trigger_core.sv
// Hall-effect key scanner with rapid trigger, one sample per beat.
//
// Sample channel: sample_valid / sample_stall carry key_index and adc_sample.
// Result channel: result_valid / result_stall carry key_id, pressed, changed.
// A beat moves when valid is high and stall is low at a rising clock edge.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write registers only while no sample is in flight.
//
// A sample is held in the work stage with its entry read, then its result in
// the result register. Throughput: one sample per cycle while result_stall is
// low, set by the single read-modify-write of the per-key entry store (one
// read port, one write port, with a bypass for back-to-back samples of one key).
// Reset: all keys start cleared through per-entry written flags, so the block
// takes samples right after reset with no clearing pass; registers take their
// default values. When result_stall is held, the result register holds, the
// entry being worked on holds, and sample_stall rises once both are full.
// Keys at or above NUM_KEYS give pressed 0, changed 0 and leave state alone.

`default_nettype none

module hall_key_rapid_trigger_core
    import hkrt_pkg::*;
#(
    parameter int NUM_KEYS = 128,
    parameter int ADC_BITS = 12
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 sample_valid,
    output logic                      sample_stall,
    input  wire logic [KEY_W-1:0]     key_index,
    input  wire logic [ADC_BITS-1:0]  adc_sample,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output logic      [KEY_W-1:0]     key_id,
    output logic                      pressed,
    output logic                      changed,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int AW      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int CNT_W   = $clog2(NUM_KEYS + 1);
    localparam int IDX_W   = (KEY_W > CNT_W) ? KEY_W : CNT_W;
    localparam int STATE_W = 3 * ADC_BITS + DRIFT_W + 2;

    cfg_t cfg;

    logic                accept;
    logic                out_adv;
    logic                s1_adv;
    logic [IDX_W-1:0]    key_ext;
    logic                key_in_range;

    logic                s1_valid_reg;
    logic [KEY_W-1:0]    s1_key_reg;
    logic [AW-1:0]       s1_addr_reg;
    logic [ADC_BITS-1:0] s1_sample_reg;
    logic                s1_inr_reg;

    logic                out_valid_reg;
    logic [KEY_W-1:0]    out_key_reg;
    logic                out_pressed_reg;
    logic                out_changed_reg;

    logic [STATE_W-1:0]  old_state;
    logic [STATE_W-1:0]  new_state;

    logic [ADC_BITS-1:0] old_baseline;
    logic [DRIFT_W-1:0]  old_drift;
    logic                old_key_down;
    logic                old_rapid;
    logic [ADC_BITS-1:0] old_deepest;
    logic [ADC_BITS-1:0] old_shallowest;
    logic [ADC_BITS-1:0] new_baseline;
    logic [DRIFT_W-1:0]  new_drift;
    logic                new_key_down;
    logic                new_rapid;
    logic [ADC_BITS-1:0] new_deepest;
    logic [ADC_BITS-1:0] new_shallowest;
    logic                upd_pressed;
    logic                upd_changed;

    hkrt_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // handshake: the work stage moves when the result register is empty or not stalled
    assign out_adv      = !out_valid_reg || !result_stall;
    assign s1_adv       = s1_valid_reg && out_adv;
    assign sample_stall = s1_valid_reg && !out_adv;
    assign accept       = sample_valid && !sample_stall;

    assign key_ext      = IDX_W'(key_index);
    assign key_in_range = key_ext < IDX_W'(NUM_KEYS);

    hkrt_key_store #(
        .DEPTH  (NUM_KEYS),
        .DATA_W (STATE_W)
    ) u_key_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (key_ext[AW-1:0]),
        .rd_data (old_state),
        .wr_en   (s1_adv && s1_inr_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (new_state)
    );

    // entry layout
    assign {old_baseline, old_drift, old_key_down, old_rapid,
            old_deepest, old_shallowest} = old_state;
    assign new_state = {new_baseline, new_drift, new_key_down, new_rapid,
                        new_deepest, new_shallowest};

    hkrt_key_update #(
        .ADC_BITS (ADC_BITS)
    ) u_key_update (
        .cfg            (cfg),
        .sample         (s1_sample_reg),
        .old_baseline   (old_baseline),
        .old_drift      (old_drift),
        .old_key_down   (old_key_down),
        .old_rapid      (old_rapid),
        .old_deepest    (old_deepest),
        .old_shallowest (old_shallowest),
        .new_baseline   (new_baseline),
        .new_drift      (new_drift),
        .new_key_down   (new_key_down),
        .new_rapid      (new_rapid),
        .new_deepest    (new_deepest),
        .new_shallowest (new_shallowest),
        .pressed        (upd_pressed),
        .changed        (upd_changed)
    );

    // work stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // work stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_key_reg    <= key_index;
            s1_addr_reg   <= key_ext[AW-1:0];
            s1_sample_reg <= adc_sample;
            s1_inr_reg    <= key_in_range;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_key_reg     <= s1_key_reg;
            out_pressed_reg <= s1_inr_reg && upd_pressed;
            out_changed_reg <= s1_inr_reg && upd_changed;
        end
    end

    assign result_valid = out_valid_reg;
    assign key_id       = out_key_reg;
    assign pressed      = out_pressed_reg;
    assign changed      = out_changed_reg;

    // checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (s1_valid_reg && out_valid_reg && result_stall))
        else $error("sample stall raised with room in the pipeline");

    a_work_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_adv) |=> out_valid_reg)
        else $error("work stage beat did not reach the result register");

    a_out_of_range_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (IDX_W'(key_id) >= IDX_W'(NUM_KEYS))) |-> (!pressed && !changed))
        else $error("key beyond range reported a press or a change");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted sample lost before the work stage");

endmodule

`default_nettype wire
